>>> rtl/brws_pkg.sv
package brws_pkg;

	localparam int VAL_W      = 48;
	localparam int BS_W       = 32;
	localparam int NW_W       = 13;
	localparam int RANK_W     = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;
	localparam int MUL_CHUNK  = 16;
	localparam int MUL_STEPS  = VAL_W / MUL_CHUNK;

	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BLOCKS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_WORKERS  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WORKER_RANK  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CHECK_SMALL  = 3'd4;

	localparam logic [BS_W-1:0]   RST_BLOCK_SIZE   = 32'd4096;
	localparam logic [VAL_W-1:0]  RST_TOTAL_BLOCKS = '0;
	localparam logic [NW_W-1:0]   RST_NUM_WORKERS  = 13'd1;
	localparam logic [RANK_W-1:0] RST_WORKER_RANK  = '0;

	typedef struct packed {
		logic [47:0] file_size;
		logic        start_of_list;
	} file_t;

	typedef struct packed {
		logic        take_slice;
		logic [47:0] slice_offset;
		logic [47:0] slice_length;
		logic        slice_too_small;
		logic        range_done;
		logic [47:0] worker_block_count;
	} slice_t;

	typedef enum logic [3:0] {
		DP_NONE,
		DP_LOAD,
		DP_DIV_SHARE,
		DP_MUL_RANK,
		DP_MUL_NM1,
		DP_FIN_LIST,
		DP_END_BLK,
		DP_DIV_NB,
		DP_CAP_NB,
		DP_MUL_OFF,
		DP_CAP_OFF,
		DP_LEN_SIZE,
		DP_MUL_LEN,
		DP_CAP_LEN,
		DP_ADV,
		DP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic start_list;
		logic active;
		logic div_done;
		logic mul_done;
		logic overlap;
		logic need_off;
		logic short_owe;
	} dp_status_t;

endpackage

>>> rtl/brws_div.sv
module brws_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [brws_pkg::VAL_W-1:0]  dividend,
	input  logic [brws_pkg::BS_W-1:0]   divisor,
	output logic                        done,
	output logic [brws_pkg::VAL_W-1:0]  quotient,
	output logic [brws_pkg::BS_W-1:0]   remainder
);

	localparam int CNT_W = $clog2(brws_pkg::VAL_W);

	logic [brws_pkg::VAL_W-1:0] dvd_q;
	logic [brws_pkg::BS_W-1:0]  dsr_q;
	logic [brws_pkg::BS_W-1:0]  rem_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [brws_pkg::BS_W:0]    shifted;
	logic [brws_pkg::BS_W:0]    diff;
	logic                       ge;

	assign shifted = {rem_q, dvd_q[brws_pkg::VAL_W-1]};
	assign ge      = shifted >= {1'b0, dsr_q};
	assign diff    = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(brws_pkg::VAL_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[brws_pkg::BS_W-1:0] : shifted[brws_pkg::BS_W-1:0];
			dvd_q <= {dvd_q[brws_pkg::VAL_W-2:0], ge};
		end
	end

	assign done      = done_q;
	assign quotient  = dvd_q;
	assign remainder = rem_q;

endmodule

>>> rtl/brws_mul.sv
module brws_mul (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [brws_pkg::VAL_W-1:0]  a,
	input  logic [brws_pkg::BS_W-1:0]   b,
	output logic                        done,
	output logic [brws_pkg::VAL_W-1:0]  product
);

	localparam int CNT_W  = $clog2(brws_pkg::MUL_STEPS);
	localparam int PROD_W = brws_pkg::MUL_CHUNK + brws_pkg::BS_W;

	logic [brws_pkg::VAL_W-1:0]     a_q;
	logic [brws_pkg::BS_W-1:0]      b_q;
	logic [brws_pkg::VAL_W-1:0]     acc_q;
	logic [CNT_W-1:0]               cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic [brws_pkg::MUL_CHUNK-1:0] chunk;
	logic [PROD_W-1:0]              part;
	logic [brws_pkg::VAL_W-1:0]     part_ext;

	assign chunk    = a_q[cnt_q*brws_pkg::MUL_CHUNK +: brws_pkg::MUL_CHUNK];
	assign part     = PROD_W'(chunk) * PROD_W'(b_q);
	assign part_ext = brws_pkg::VAL_W'(part) << (cnt_q * brws_pkg::MUL_CHUNK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(brws_pkg::MUL_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					cnt_q  <= '0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + part_ext;
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

>>> rtl/brws_dp.sv
module brws_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  brws_pkg::dp_cmd_t                cmd,
	output brws_pkg::dp_status_t             status,
	input  brws_pkg::file_t                  file,
	output brws_pkg::slice_t                 slice,
	input  logic                             cfg_wr_en,
	input  logic [brws_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [brws_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int VW = brws_pkg::VAL_W;

	logic [brws_pkg::BS_W-1:0]   block_size_q;
	logic [VW-1:0]               total_blocks_q;
	logic [brws_pkg::NW_W-1:0]   num_workers_q;
	logic [brws_pkg::RANK_W-1:0] worker_rank_q;
	logic                        check_small_q;

	logic [VW-1:0] next_idx_q;
	logic [VW-1:0] owed_q;
	logic [VW-1:0] first_q;
	logic [VW-1:0] end_q;
	logic [VW-1:0] owned_q;

	logic [VW-1:0] size_q;
	logic          start_q;
	logic [VW-1:0] share_q;
	logic [VW-1:0] nb_q;
	logic          take_q;
	logic [VW-1:0] off_q;
	logic [VW-1:0] len_q;
	logic          small_q;
	brws_pkg::slice_t out_q;

	logic [brws_pkg::BS_W-1:0] bs_eff;
	logic [brws_pkg::NW_W-1:0] n_eff;
	logic                      rank_ok;
	logic                      rank_last;
	logic [VW:0]               sum_nb;
	logic [VW-1:0]             inner;
	logic [VW-1:0]             remaining;
	logic                      need_off;

	logic                      div_start;
	logic [VW-1:0]             div_dvd;
	logic [brws_pkg::BS_W-1:0] div_dsr;
	logic                      div_done;
	logic [VW-1:0]             div_q;
	logic [brws_pkg::BS_W-1:0] div_r;

	logic                      mul_start;
	logic [VW-1:0]             mul_a;
	logic [brws_pkg::BS_W-1:0] mul_b;
	logic                      mul_done;
	logic [VW-1:0]             mul_p;

	assign bs_eff    = (block_size_q == '0) ? brws_pkg::BS_W'(1) : block_size_q;
	assign n_eff     = (num_workers_q == '0) ? brws_pkg::NW_W'(1) : num_workers_q;
	assign rank_ok   = {1'b0, worker_rank_q} < n_eff;
	assign rank_last = {1'b0, worker_rank_q} == (n_eff - 1'b1);
	assign sum_nb    = {1'b0, next_idx_q} + {1'b0, nb_q};
	assign need_off  = first_q > next_idx_q;
	assign inner     = first_q - next_idx_q;
	assign remaining = nb_q - (need_off ? inner : '0);

	always_comb begin
		status            = '0;
		status.start_list = start_q;
		status.active     = (size_q != '0) && (owned_q != '0) && (next_idx_q < end_q);
		status.div_done   = div_done;
		status.mul_done   = mul_done;
		status.overlap    = sum_nb > {1'b0, first_q};
		status.need_off   = need_off;
		status.short_owe  = owed_q < remaining;
	end

	always_comb begin
		div_start = (cmd.op == brws_pkg::DP_DIV_SHARE) || (cmd.op == brws_pkg::DP_DIV_NB);
		if (cmd.op == brws_pkg::DP_DIV_SHARE) begin
			div_dvd = total_blocks_q;
			div_dsr = brws_pkg::BS_W'(n_eff);
		end else begin
			div_dvd = size_q;
			div_dsr = bs_eff;
		end
	end

	always_comb begin
		mul_start = 1'b0;
		mul_a     = owed_q;
		mul_b     = bs_eff;
		unique case (cmd.op)
			brws_pkg::DP_MUL_RANK: begin
				mul_start = 1'b1;
				mul_a     = div_q;
				mul_b     = brws_pkg::BS_W'(worker_rank_q);
			end
			brws_pkg::DP_MUL_NM1: begin
				mul_start = 1'b1;
				mul_a     = share_q;
				mul_b     = brws_pkg::BS_W'(n_eff - 1'b1);
			end
			brws_pkg::DP_MUL_OFF: begin
				mul_start = 1'b1;
				mul_a     = inner;
			end
			brws_pkg::DP_MUL_LEN: begin
				mul_start = 1'b1;
			end
			default: begin
			end
		endcase
	end

	brws_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dvd),
		.divisor   (div_dsr),
		.done      (div_done),
		.quotient  (div_q),
		.remainder (div_r)
	);

	brws_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.done    (mul_done),
		.product (mul_p)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q   <= brws_pkg::RST_BLOCK_SIZE;
			total_blocks_q <= brws_pkg::RST_TOTAL_BLOCKS;
			num_workers_q  <= brws_pkg::RST_NUM_WORKERS;
			worker_rank_q  <= brws_pkg::RST_WORKER_RANK;
			check_small_q  <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				brws_pkg::CFG_BLOCK_SIZE:   block_size_q   <= cfg_data[brws_pkg::BS_W-1:0];
				brws_pkg::CFG_TOTAL_BLOCKS: total_blocks_q <= cfg_data[VW-1:0];
				brws_pkg::CFG_NUM_WORKERS:  num_workers_q  <= cfg_data[brws_pkg::NW_W-1:0];
				brws_pkg::CFG_WORKER_RANK:  worker_rank_q  <= cfg_data[brws_pkg::RANK_W-1:0];
				brws_pkg::CFG_CHECK_SMALL:  check_small_q  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_idx_q <= '0;
			owed_q     <= '0;
			first_q    <= '0;
			end_q      <= '0;
			owned_q    <= '0;
		end else begin
			unique case (cmd.op)
				brws_pkg::DP_MUL_NM1: begin
					first_q <= mul_p;
				end
				brws_pkg::DP_FIN_LIST: begin
					next_idx_q <= '0;
					if (!rank_ok) begin
						first_q <= '0;
						owed_q  <= '0;
						owned_q <= '0;
					end else if (rank_last) begin
						owed_q  <= total_blocks_q - mul_p;
						owned_q <= total_blocks_q - mul_p;
					end else begin
						owed_q  <= share_q;
						owned_q <= share_q;
					end
				end
				brws_pkg::DP_END_BLK: begin
					end_q <= first_q + owned_q;
				end
				brws_pkg::DP_LEN_SIZE: begin
					owed_q <= owed_q - remaining;
				end
				brws_pkg::DP_CAP_LEN: begin
					owed_q <= '0;
				end
				brws_pkg::DP_ADV: begin
					next_idx_q <= sum_nb[VW] ? '1 : sum_nb[VW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			brws_pkg::DP_LOAD: begin
				size_q  <= file.file_size;
				start_q <= file.start_of_list;
				take_q  <= 1'b0;
				off_q   <= '0;
				len_q   <= '0;
				small_q <= 1'b0;
			end
			brws_pkg::DP_MUL_RANK: begin
				share_q <= div_q;
			end
			brws_pkg::DP_CAP_NB: begin
				nb_q <= div_q + VW'(div_r != '0);
			end
			brws_pkg::DP_CAP_OFF: begin
				off_q <= mul_p;
			end
			brws_pkg::DP_LEN_SIZE: begin
				len_q  <= size_q - off_q;
				take_q <= 1'b1;
			end
			brws_pkg::DP_CAP_LEN: begin
				len_q  <= mul_p;
				take_q <= 1'b1;
			end
			brws_pkg::DP_ADV: begin
				small_q <= take_q && check_small_q && (len_q < VW'(bs_eff));
			end
			brws_pkg::DP_OUT: begin
				out_q.take_slice         <= take_q;
				out_q.slice_offset       <= off_q;
				out_q.slice_length       <= len_q;
				out_q.slice_too_small    <= small_q;
				out_q.range_done         <= (owned_q == '0) || (next_idx_q >= end_q);
				out_q.worker_block_count <= owned_q;
			end
			default: begin
			end
		endcase
	end

	assign slice = out_q;

endmodule

>>> rtl/brws_ctrl.sv
module brws_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 file_valid,
	output logic                 file_stall,
	output logic                 slice_valid,
	input  logic                 slice_stall,
	output brws_pkg::dp_cmd_t    cmd,
	input  brws_pkg::dp_status_t status
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_BEGIN,
		S_SH_DIV,
		S_SH_MUL1,
		S_SH_MUL2,
		S_SH_END,
		S_CHECK,
		S_NB_DIV,
		S_OVL,
		S_OFF_MUL,
		S_LEN,
		S_LEN_MUL,
		S_ADV,
		S_DONE
	} state_t;

	state_t state_q;
	logic   slice_valid_q;
	logic   out_free;

	assign out_free = !slice_valid_q || !slice_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			slice_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				slice_valid_q <= 1'b1;
			end else if (!slice_stall) begin
				slice_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE:    if (file_valid) state_q <= S_BEGIN;
				S_BEGIN:   state_q <= status.start_list ? S_SH_DIV : S_CHECK;
				S_SH_DIV:  if (status.div_done) state_q <= S_SH_MUL1;
				S_SH_MUL1: if (status.mul_done) state_q <= S_SH_MUL2;
				S_SH_MUL2: if (status.mul_done) state_q <= S_SH_END;
				S_SH_END:  state_q <= S_CHECK;
				S_CHECK:   state_q <= status.active ? S_NB_DIV : S_DONE;
				S_NB_DIV:  if (status.div_done) state_q <= S_OVL;
				S_OVL: begin
					priority if (!status.overlap) state_q <= S_ADV;
					else if (status.need_off) state_q <= S_OFF_MUL;
					else state_q <= S_LEN;
				end
				S_OFF_MUL: if (status.mul_done) state_q <= S_LEN;
				S_LEN:     state_q <= status.short_owe ? S_LEN_MUL : S_ADV;
				S_LEN_MUL: if (status.mul_done) state_q <= S_ADV;
				S_ADV:     state_q <= S_DONE;
				S_DONE:    if (out_free) state_q <= S_IDLE;
				default:   state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd.op = brws_pkg::DP_NONE;
		unique case (state_q)
			S_IDLE:    if (file_valid) cmd.op = brws_pkg::DP_LOAD;
			S_BEGIN:   if (status.start_list) cmd.op = brws_pkg::DP_DIV_SHARE;
			S_SH_DIV:  if (status.div_done) cmd.op = brws_pkg::DP_MUL_RANK;
			S_SH_MUL1: if (status.mul_done) cmd.op = brws_pkg::DP_MUL_NM1;
			S_SH_MUL2: if (status.mul_done) cmd.op = brws_pkg::DP_FIN_LIST;
			S_SH_END:  cmd.op = brws_pkg::DP_END_BLK;
			S_CHECK:   if (status.active) cmd.op = brws_pkg::DP_DIV_NB;
			S_NB_DIV:  if (status.div_done) cmd.op = brws_pkg::DP_CAP_NB;
			S_OVL:     if (status.overlap && status.need_off) cmd.op = brws_pkg::DP_MUL_OFF;
			S_OFF_MUL: if (status.mul_done) cmd.op = brws_pkg::DP_CAP_OFF;
			S_LEN: begin
				cmd.op = status.short_owe ? brws_pkg::DP_MUL_LEN : brws_pkg::DP_LEN_SIZE;
			end
			S_LEN_MUL: if (status.mul_done) cmd.op = brws_pkg::DP_CAP_LEN;
			S_ADV:     cmd.op = brws_pkg::DP_ADV;
			S_DONE:    if (out_free) cmd.op = brws_pkg::DP_OUT;
			default:   cmd.op = brws_pkg::DP_NONE;
		endcase
	end

	assign file_stall  = state_q != S_IDLE;
	assign slice_valid = slice_valid_q;

endmodule

>>> rtl/block_range_work_splitter.sv
// Splits a list of files, seen as one contiguous run of blocks, among workers
// and reports this worker's share of each file.
// The file channel carries one file size per transfer; start_of_list marks the
// first file of a list and restarts block counting from the current registers.
// The slice channel returns exactly one result per file, in order.
// Configuration is written through the plain write port; the user must write it
// only while the block is idle; the block itself has no guard for this.
// Each file passes through the 48-step radix-2 divider that counts its blocks
// and, where needed, the three-step multiplier. A file that starts a list
// first takes a divide and two multiplies that set up the owned range.
// A zero-size file, or one that arrives after the range is done, skips the
// block count and the slice arithmetic.
// One file is worked on at a time; the next one is taken while the previous
// result still waits in the output register.
// When the receiver stalls, the result holds and the block stops after
// finishing the following file.
// Reset restores the register defaults and leaves the owned range empty.
module block_range_work_splitter (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             file_valid,
	output logic                             file_stall,
	input  brws_pkg::file_t                  file,
	output logic                             slice_valid,
	input  logic                             slice_stall,
	output brws_pkg::slice_t                 slice,
	input  logic                             cfg_wr_en,
	input  logic [brws_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [brws_pkg::CFG_DATA_W-1:0]  cfg_data
);

	brws_pkg::dp_cmd_t    cmd;
	brws_pkg::dp_status_t status;

	brws_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.file_valid  (file_valid),
		.file_stall  (file_stall),
		.slice_valid (slice_valid),
		.slice_stall (slice_stall),
		.cmd         (cmd),
		.status      (status)
	);

	brws_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.file      (file),
		.slice     (slice),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

>>> rtl/brws_checker.sv
module brws_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             file_valid,
	input logic             file_stall,
	input logic             slice_valid,
	input logic             slice_stall,
	input brws_pkg::slice_t slice
);

	logic [1:0] pend_q;
	logic       in_xfer;
	logic       out_xfer;

	assign in_xfer  = file_valid && !file_stall;
	assign out_xfer = slice_valid && !slice_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(in_xfer) - 2'(out_xfer);
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		slice_valid && slice_stall |=> slice_valid && $stable(slice))
		else $error("Stalled result changed.");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		slice_valid |-> pend_q != 2'd0)
		else $error("Result without a pending file.");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("More than two files in flight.");

	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		slice_valid && !slice.take_slice |->
			slice.slice_offset == '0 && slice.slice_length == '0 && !slice.slice_too_small)
		else $error("Slice fields set without a slice.");

	a_empty_done: assert property (@(posedge clk) disable iff (!arst_n)
		slice_valid && slice.worker_block_count == '0 |-> slice.range_done && !slice.take_slice)
		else $error("Empty range not reported as done.");

endmodule

bind block_range_work_splitter brws_checker u_checker (.*);
